// ----- design/assert_macros.svh -----
// Assertion macros used by the checker file.
// Each macro samples on the rising edge of clock.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property checked only while reset is low.
`define ASSERT_CLK(label, prop, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (prop)) else $error(msg);

// Property checked on every edge, including during reset.
`define ASSERT_ALWAYS(label, prop, msg) \
   label: assert property (@(posedge clock) (prop)) else $error(msg);

`endif

// ----- design/pdw_pkg.sv -----
`default_nettype none

package pdw_pkg;

   // Field widths.
   localparam int unsigned ECHO_W   = 16;
   localparam int unsigned DIST_W   = 11;
   localparam int unsigned STATUS_W = 2;
   localparam int unsigned SETTLE_W = 4;
   localparam int unsigned FAR_W    = 8;
   localparam int unsigned CSR_IDX_W = 2;
   localparam int unsigned CSR_DATA_W = 11;

   typedef logic [STATUS_W-1:0] status_type;

   // Status codes.
   localparam status_type ST_SAFE    = 2'd0;
   localparam status_type ST_CAUTION = 2'd1;
   localparam status_type ST_DANGER  = 2'd2;

   // Item kinds on the tuser bit.
   localparam logic MODE_MOTION = 1'b0;
   localparam logic MODE_ECHO   = 1'b1;

   // Register indexes.
   localparam logic [CSR_IDX_W-1:0] REG_DISTANCE_LIMIT = 2'd0;
   localparam logic [CSR_IDX_W-1:0] REG_SETTLE_SAMPLES = 2'd1;
   localparam logic [CSR_IDX_W-1:0] REG_IDLE_LIMIT     = 2'd2;

   // Register reset values.
   localparam logic [DIST_W-1:0]   DISTANCE_LIMIT_RST = 11'd150;
   localparam logic [SETTLE_W-1:0] SETTLE_SAMPLES_RST = 4'd3;
   localparam logic [FAR_W-1:0]    IDLE_LIMIT_RST     = 8'd60;

   // Echo time to centimeters is floor(t / 58). The reciprocal
   // ceil(2^22 / 58) gives the exact quotient for every 16-bit echo.
   localparam int unsigned DIV_SHIFT = 22;
   localparam int unsigned RECIP_W   = 17;
   localparam logic [RECIP_W-1:0] DIV_RECIP = 17'd72316;
   localparam int unsigned PROD_W    = ECHO_W + RECIP_W;

   // Largest distance a 16-bit echo can give.
   localparam logic [DIST_W-1:0] DIST_MAX = 11'd1129;

endpackage

`default_nettype wire

// ----- design/pdw_div58.sv -----
`default_nettype none

// Converts an echo width in microseconds to whole centimeters.
module pdw_div58 import pdw_pkg::*; (
   input  wire logic [ECHO_W-1:0] echo_us,
   output logic      [DIST_W-1:0] dist_cm
);

   logic [PROD_W-1:0] prod;

   // Multiply by the scaled reciprocal of 58 and keep the integer part.
   assign prod    = PROD_W'(echo_us) * PROD_W'(DIV_RECIP);
   assign dist_cm = prod[DIV_SHIFT +: DIST_W];

endmodule

`default_nettype wire

// ----- design/presence_distance_warn_fsm.sv -----
`default_nettype none

// Presence and distance warning controller.
// Input channel req_: one item per motion event (tuser = 0) or finished echo
// (tuser = 1, tdata = echo width in microseconds). Result channel rsp_: one
// item per input item, carrying the shown status, the status-applied and
// went-idle flags, the sampling flag and the distance of the echo.
// Configuration: csr_we writes csr_wdata into the register picked by csr_addr
// (0 distance limit, 1 settle samples, 2 idle limit); write only while idle.
// An accepted item is held in the input register, and its result is loaded
// into the output register once the output side is free; rsp_tvalid then
// rises. Throughput: one item per cycle while the receiver keeps up; the
// distance multiply, the compares and the state update sit between the input
// register and the output register.
// Reset (synchronous, active high) empties both registers, restores the
// register defaults and returns to safe with sampling off.
// When the receiver stalls, the result holds in the output register while the
// input register can still take one more item; req_tready then drops.
module presence_distance_warn_fsm import pdw_pkg::*; (
   input  wire logic                  clock,
   input  wire logic                  reset,
   // Input channel.
   input  wire logic                  req_tvalid,
   output logic                       req_tready,
   input  wire logic [ECHO_W-1:0]     req_tdata,   // [15:0] echo_us
   input  wire logic [0:0]            req_tuser,   // [0] mode
   // Result channel.
   output logic                       rsp_tvalid,
   input  wire logic                  rsp_tready,
   output logic [15:0]                rsp_tdata,   // [1:0] warn_status, [2] status_set,
                                                   // [3] sampling_active, [4] went_idle,
                                                   // [15:5] distance_cm
   // Configuration port.
   input  wire logic                  csr_we,
   input  wire logic [CSR_IDX_W-1:0]  csr_addr,
   input  wire logic [CSR_DATA_W-1:0] csr_wdata
);

   // Configuration registers.
   logic [DIST_W-1:0]   dist_limit_ff;
   logic [SETTLE_W-1:0] settle_samp_ff;
   logic [FAR_W-1:0]    idle_limit_ff;

   // Input register.
   logic              in_valid_ff, in_valid_in;
   logic              in_mode_ff;
   logic [ECHO_W-1:0] in_echo_ff;

   // Output register.
   logic        rsp_valid_ff, rsp_valid_in;
   logic [15:0] rsp_data_ff, rsp_data_in;

   // Controller state.
   status_type        shown_ff, shown_in;
   status_type        reqst_ff, reqst_in;
   logic signed [4:0] settle_ff, settle_in;
   logic [FAR_W-1:0]  far_ff, far_in;
   logic              samp_ff, samp_in;

   logic              set_flag;
   logic              idle_flag;
   logic [DIST_W-1:0] dist_item;
   logic [DIST_W-1:0] div_dist;
   logic              advance;
   logic              take;

   pdw_div58 u_div (
      .echo_us (in_echo_ff),
      .dist_cm (div_dist)
   );

   // Handshake: the output register frees up when empty or being taken.
   assign advance    = !rsp_valid_ff || rsp_tready;
   assign take       = in_valid_ff && advance;
   assign req_tready = !in_valid_ff || advance;
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;

   always_comb begin
      in_valid_in = in_valid_ff;
      if (req_tready) begin
         in_valid_in = req_tvalid;
      end else if (take) begin
         in_valid_in = 1'b0;
      end
   end

   assign rsp_valid_in = advance ? in_valid_ff : rsp_valid_ff;

   // Next state and result for the item in the input register.
   always_comb begin
      shown_in  = shown_ff;
      reqst_in  = reqst_ff;
      settle_in = settle_ff;
      far_in    = far_ff;
      samp_in   = samp_ff;
      set_flag  = 1'b0;
      idle_flag = 1'b0;
      dist_item = '0;
      if (in_mode_ff == MODE_MOTION) begin
         // Motion restarts the idle count and wakes the sampler.
         far_in = '0;
         if (!samp_ff) begin
            samp_in   = 1'b1;
            shown_in  = ST_CAUTION;
            reqst_in  = ST_CAUTION;
            set_flag  = 1'b1;
            settle_in = 5'sd0;
         end
      end else if (samp_ff) begin
         dist_item = div_dist;
         if (div_dist > dist_limit_ff) begin
            // Far sample.
            if (far_ff != '1) begin
               far_in = far_ff + 8'd1;
            end
            if (reqst_ff != ST_CAUTION) begin
               reqst_in  = ST_CAUTION;
               settle_in = -5'sd1;
            end
         end else begin
            // Near or equal sample.
            if (far_ff != '0) begin
               far_in = far_ff - 8'd1;
            end
            if ((div_dist < dist_limit_ff) && (reqst_ff != ST_DANGER)) begin
               reqst_in  = ST_DANGER;
               settle_in = -5'sd1;
            end
         end
         // Apply the request once it has settled.
         if (settle_in < $signed({1'b0, settle_samp_ff})) begin
            settle_in = settle_in + 5'sd1;
         end else if (shown_in != reqst_in) begin
            shown_in = reqst_in;
            set_flag = 1'b1;
         end
         // Too many far samples: stop sampling and go safe.
         if (far_in >= idle_limit_ff) begin
            if (reqst_in != ST_SAFE) begin
               shown_in = ST_SAFE;
               reqst_in = ST_SAFE;
               set_flag = 1'b1;
            end
            samp_in   = 1'b0;
            idle_flag = 1'b1;
         end
      end
      rsp_data_in = {dist_item, idle_flag, samp_in, set_flag, shown_in};
   end

   // Control registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff    <= 1'b0;
         rsp_valid_ff   <= 1'b0;
         shown_ff       <= ST_SAFE;
         reqst_ff       <= ST_SAFE;
         settle_ff      <= 5'sd0;
         far_ff         <= '0;
         samp_ff        <= 1'b0;
         dist_limit_ff  <= DISTANCE_LIMIT_RST;
         settle_samp_ff <= SETTLE_SAMPLES_RST;
         idle_limit_ff  <= IDLE_LIMIT_RST;
      end else begin
         in_valid_ff  <= in_valid_in;
         rsp_valid_ff <= rsp_valid_in;
         if (take) begin
            shown_ff  <= shown_in;
            reqst_ff  <= reqst_in;
            settle_ff <= settle_in;
            far_ff    <= far_in;
            samp_ff   <= samp_in;
         end
         if (csr_we) begin
            case (csr_addr)
               REG_DISTANCE_LIMIT: dist_limit_ff  <= csr_wdata[DIST_W-1:0];
               REG_SETTLE_SAMPLES: settle_samp_ff <= csr_wdata[SETTLE_W-1:0];
               REG_IDLE_LIMIT:     idle_limit_ff  <= csr_wdata[FAR_W-1:0];
               default: ;
            endcase
         end
      end
   end

   // Payload registers.
   always_ff @(posedge clock) begin
      if (req_tvalid && req_tready) begin
         in_mode_ff <= req_tuser[0];
         in_echo_ff <= req_tdata;
      end
      if (take) begin
         rsp_data_ff <= rsp_data_in;
      end
   end

endmodule

`default_nettype wire

// ----- design/pdw_checker.sv -----
`default_nettype none

`include "assert_macros.svh"

// Port-level checks for the warning controller.
module pdw_checker import pdw_pkg::*; (
   input wire logic        clock,
   input wire logic        reset,
   input wire logic        rsp_tvalid,
   input wire logic        rsp_tready,
   input wire logic [15:0] rsp_tdata
);

   logic [STATUS_W-1:0] warn_status;
   logic                sampling_active;
   logic                went_idle;
   logic [DIST_W-1:0]   distance_cm;

   assign warn_status     = rsp_tdata[1:0];
   assign sampling_active = rsp_tdata[3];
   assign went_idle       = rsp_tdata[4];
   assign distance_cm     = rsp_tdata[15:5];

   // Nothing is offered in the cycle after reset.
   `ASSERT_ALWAYS(a_reset_empty, reset |=> !rsp_tvalid, "result offered right after reset")

   // A stalled result holds.
   `ASSERT_CLK(a_stall_hold, rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata), "stalled result changed")

   // Going idle always ends sampling in the safe status.
   `ASSERT_CLK(a_idle_safe, rsp_tvalid && went_idle |-> !sampling_active && (warn_status == ST_SAFE), "idle without safe status")

   // A nonzero distance with sampling off must be flagged as going idle.
   `ASSERT_CLK(a_dist_idle, rsp_tvalid && (distance_cm != '0) && !sampling_active |-> went_idle, "echo measured while not sampling")

   // Status code and distance stay in range.
   `ASSERT_CLK(a_range, rsp_tvalid |-> (warn_status != 2'd3) && (distance_cm <= DIST_MAX), "result field out of range")

endmodule

bind presence_distance_warn_fsm pdw_checker u_pdw_checker (
   .clock      (clock),
   .reset      (reset),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata)
);

`default_nettype wire

// ----- test/presence_distance_warn_fsm_tb.sv -----
`timescale 1ns / 1ps

module presence_distance_warn_fsm_tb;
   import pdw_pkg::*;

   localparam int unsigned DRAIN_CYCLES = 4;
   localparam int unsigned RANDOM_ITEMS = 1500;

   // One result item, unpacked from rsp_tdata.
   typedef struct packed {
      status_type        warn_status;
      logic              status_set;
      logic              sampling_active;
      logic              went_idle;
      logic [DIST_W-1:0] distance_cm;
   } warn_result_type;

   typedef enum logic { ROW_ITEM, ROW_CSR } plan_kind_type;

   // One step of the directed sequence: either an item or a register write.
   typedef struct packed {
      plan_kind_type         kind;
      logic                  mode;
      logic [ECHO_W-1:0]     echo_us;
      logic [CSR_IDX_W-1:0]  reg_idx;
      logic [CSR_DATA_W-1:0] reg_val;
      logic                  typed;
      warn_result_type       typed_res;
   } plan_row_type;

   localparam warn_result_type NO_RES = '0;
   localparam int unsigned PLAN_ROWS = 33;

   // Directed sequence. Rows with a typed result are compared against that
   // literal; the rest are compared against the predictor.
   localparam plan_row_type DIRECTED_PLAN [PLAN_ROWS] = '{
      // Echo while sampling is off is ignored.
      '{ROW_ITEM, MODE_ECHO,   16'hFFFF, REG_DISTANCE_LIMIT, 11'd0, 1'b1,
        '{ST_SAFE, 1'b0, 1'b0, 1'b0, 11'd0}},
      // Motion starts sampling and applies caution.
      '{ROW_ITEM, MODE_MOTION, 16'h0000, REG_DISTANCE_LIMIT, 11'd0, 1'b1,
        '{ST_CAUTION, 1'b1, 1'b1, 1'b0, 11'd0}},
      // Longest echo gives the largest distance.
      '{ROW_ITEM, MODE_ECHO,   16'hFFFF, REG_DISTANCE_LIMIT, 11'd0, 1'b1,
        '{ST_CAUTION, 1'b0, 1'b1, 1'b0, 11'd1129}},
      // Near samples settle into danger.
      '{ROW_ITEM, MODE_ECHO,   16'h0000, REG_DISTANCE_LIMIT, 11'd0, 1'b0, NO_RES},
      '{ROW_ITEM, MODE_ECHO,   16'h0000, REG_DISTANCE_LIMIT, 11'd0, 1'b0, NO_RES},
      '{ROW_ITEM, MODE_ECHO,   16'h0000, REG_DISTANCE_LIMIT, 11'd0, 1'b0, NO_RES},
      '{ROW_ITEM, MODE_ECHO,   16'h0000, REG_DISTANCE_LIMIT, 11'd0, 1'b0, NO_RES},
      '{ROW_ITEM, MODE_ECHO,   16'h0000, REG_DISTANCE_LIMIT, 11'd0, 1'b0, NO_RES},
      // Distance equal to the limit, then just past it.
      '{ROW_ITEM, MODE_ECHO,   16'd8700, REG_DISTANCE_LIMIT, 11'd0, 1'b0, NO_RES},
      '{ROW_ITEM, MODE_ECHO,   16'd8757, REG_DISTANCE_LIMIT, 11'd0, 1'b0, NO_RES},
      '{ROW_ITEM, MODE_ECHO,   16'd8758, REG_DISTANCE_LIMIT, 11'd0, 1'b0, NO_RES},
      // Motion while sampling only clears the far count.
      '{ROW_ITEM, MODE_MOTION, 16'hFFFF, REG_DISTANCE_LIMIT, 11'd0, 1'b0, NO_RES},
      '{ROW_ITEM, MODE_ECHO,   16'h5555, REG_DISTANCE_LIMIT, 11'd0, 1'b0, NO_RES},
      '{ROW_ITEM, MODE_ECHO,   16'hAAAA, REG_DISTANCE_LIMIT, 11'd0, 1'b0, NO_RES},
      // Low settings: every far sample stops sampling.
      '{ROW_CSR,  MODE_ECHO,   16'h0000, REG_IDLE_LIMIT,     11'd1, 1'b0, NO_RES},
      '{ROW_CSR,  MODE_ECHO,   16'h0000, REG_SETTLE_SAMPLES, 11'd0, 1'b0, NO_RES},
      '{ROW_CSR,  MODE_ECHO,   16'h0000, REG_DISTANCE_LIMIT, 11'd0, 1'b0, NO_RES},
      '{ROW_ITEM, MODE_ECHO,   16'd58,   REG_DISTANCE_LIMIT, 11'd0, 1'b0, NO_RES},
      '{ROW_ITEM, MODE_ECHO,   16'h0000, REG_DISTANCE_LIMIT, 11'd0, 1'b1,
        '{ST_SAFE, 1'b0, 1'b0, 1'b0, 11'd0}},
      '{ROW_ITEM, MODE_MOTION, 16'h0000, REG_DISTANCE_LIMIT, 11'd0, 1'b1,
        '{ST_CAUTION, 1'b1, 1'b1, 1'b0, 11'd0}},
      // Zero distance against a zero limit counts as equal.
      '{ROW_ITEM, MODE_ECHO,   16'h0000, REG_DISTANCE_LIMIT, 11'd0, 1'b0, NO_RES},
      // High settings: even the longest echo is near.
      '{ROW_CSR,  MODE_ECHO,   16'h0000, REG_DISTANCE_LIMIT, 11'd1200, 1'b0, NO_RES},
      '{ROW_CSR,  MODE_ECHO,   16'h0000, REG_SETTLE_SAMPLES, 11'd15,  1'b0, NO_RES},
      '{ROW_CSR,  MODE_ECHO,   16'h0000, REG_IDLE_LIMIT,     11'd255, 1'b0, NO_RES},
      '{ROW_ITEM, MODE_ECHO,   16'hFFFF, REG_DISTANCE_LIMIT, 11'd0, 1'b0, NO_RES},
      '{ROW_ITEM, MODE_ECHO,   16'h0000, REG_DISTANCE_LIMIT, 11'd0, 1'b0, NO_RES},
      // Idle limit of zero: any echo stops sampling.
      '{ROW_CSR,  MODE_ECHO,   16'h0000, REG_IDLE_LIMIT,     11'd0, 1'b0, NO_RES},
      '{ROW_ITEM, MODE_ECHO,   16'd1000, REG_DISTANCE_LIMIT, 11'd0, 1'b0, NO_RES},
      '{ROW_ITEM, MODE_MOTION, 16'h0000, REG_DISTANCE_LIMIT, 11'd0, 1'b0, NO_RES},
      '{ROW_ITEM, MODE_ECHO,   16'h0000, REG_DISTANCE_LIMIT, 11'd0, 1'b0, NO_RES},
      // Back to the reset settings.
      '{ROW_CSR,  MODE_ECHO,   16'h0000, REG_DISTANCE_LIMIT, 11'd150, 1'b0, NO_RES},
      '{ROW_CSR,  MODE_ECHO,   16'h0000, REG_SETTLE_SAMPLES, 11'd3,   1'b0, NO_RES},
      '{ROW_CSR,  MODE_ECHO,   16'h0000, REG_IDLE_LIMIT,     11'd60,  1'b0, NO_RES}
   };

   logic                  clock = 1'b0;
   logic                  reset = 1'b1;
   logic                  req_tvalid = 1'b0;
   logic                  req_tready;
   logic [ECHO_W-1:0]     req_tdata = '0;
   logic [0:0]            req_tuser = '0;
   logic                  rsp_tvalid;
   logic                  rsp_tready = 1'b0;
   logic [15:0]           rsp_tdata;
   logic                  csr_we = 1'b0;
   logic [CSR_IDX_W-1:0]  csr_addr = '0;
   logic [CSR_DATA_W-1:0] csr_wdata = '0;

   presence_distance_warn_fsm dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .csr_we     (csr_we),
      .csr_addr   (csr_addr),
      .csr_wdata  (csr_wdata)
   );

   always #5 clock = ~clock;

   // Predicted warning state and register copies.
   logic [DIST_W-1:0]   limit_cm    = DISTANCE_LIMIT_RST;
   logic [SETTLE_W-1:0] settle_need = SETTLE_SAMPLES_RST;
   logic [FAR_W-1:0]    idle_far    = IDLE_LIMIT_RST;
   status_type          shown_st    = ST_SAFE;
   status_type          asked_st    = ST_SAFE;
   int                  settle_cnt  = 0;
   int                  far_cnt     = 0;
   logic                sampling    = 1'b0;

   warn_result_type warn_queue[$];
   int unsigned     fail_count = 0;

   // Sender pacing.
   int unsigned burst_left = 0;
   int unsigned gap_len = 0;
   bit          steady = 1'b0;

   // Works out the result of one item and advances the predicted state.
   function automatic warn_result_type step_warning(input logic mode,
                                                    input logic [ECHO_W-1:0] echo_us);
      warn_result_type res;
      int unsigned     cm;
      res = '0;
      if (mode == MODE_MOTION) begin
         far_cnt = 0;
         if (!sampling) begin
            sampling = 1'b1;
            shown_st = ST_CAUTION;
            asked_st = ST_CAUTION;
            res.status_set = 1'b1;
            settle_cnt = 0;
         end
      end else if (sampling) begin
         cm = (echo_us / 29) / 2;
         res.distance_cm = cm[DIST_W-1:0];
         if (cm > limit_cm) begin
            if (far_cnt < 255) far_cnt++;
            if (asked_st != ST_CAUTION) begin
               asked_st = ST_CAUTION;
               settle_cnt = -1;
            end
         end else begin
            if (far_cnt > 0) far_cnt--;
            if (cm < limit_cm && asked_st != ST_DANGER) begin
               asked_st = ST_DANGER;
               settle_cnt = -1;
            end
         end
         // A request is applied only once it has held for enough samples.
         if (settle_cnt < int'(settle_need)) begin
            settle_cnt++;
         end else if (shown_st != asked_st) begin
            shown_st = asked_st;
            res.status_set = 1'b1;
         end
         // Too many far samples: stop and fall back to safe.
         if (far_cnt >= idle_far) begin
            if (asked_st != ST_SAFE) begin
               shown_st = ST_SAFE;
               asked_st = ST_SAFE;
               res.status_set = 1'b1;
            end
            sampling = 1'b0;
            res.went_idle = 1'b1;
         end
      end
      res.warn_status = shown_st;
      res.sampling_active = sampling;
      return res;
   endfunction

   // Echo width that lands on a given distance, with a random remainder.
   function automatic logic [ECHO_W-1:0] echo_for(input int unsigned cm);
      int unsigned us;
      us = cm * 58 + $urandom_range(0, 57);
      if (us > 65535) us = 65535;
      return us[ECHO_W-1:0];
   endfunction

   // Offers one item in the current burst and records its expected result.
   task automatic send_item(input logic mode, input logic [ECHO_W-1:0] echo_us,
                            input logic typed, input warn_result_type typed_res);
      warn_result_type res;
      if (burst_left == 0) begin
         burst_left = $urandom_range(1, 24);
         gap_len = steady ? 0 : $urandom_range(0, 6);
         if (gap_len != 0) begin
            req_tvalid <= 1'b0;
            repeat (gap_len) @(posedge clock);
         end
      end
      burst_left--;
      req_tvalid <= 1'b1;
      req_tuser  <= mode;
      req_tdata  <= echo_us;
      do @(posedge clock); while (!req_tready);
      res = step_warning(mode, echo_us);
      warn_queue.push_back(typed ? typed_res : res);
   endtask

   // Register write, issued only once every expected result has arrived.
   task automatic write_reg(input logic [CSR_IDX_W-1:0] idx,
                            input logic [CSR_DATA_W-1:0] val);
      req_tvalid <= 1'b0;
      while (warn_queue.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      csr_we    <= 1'b1;
      csr_addr  <= idx;
      csr_wdata <= val;
      @(posedge clock);
      csr_we <= 1'b0;
      case (idx)
         REG_DISTANCE_LIMIT: limit_cm = val[DIST_W-1:0];
         REG_SETTLE_SAMPLES: settle_need = val[SETTLE_W-1:0];
         REG_IDLE_LIMIT:     idle_far = val[FAR_W-1:0];
         default: ;
      endcase
      @(posedge clock);
   endtask

   task automatic check_field(input string name, input int unsigned want,
                              input int unsigned got);
      if (want != got) begin
         $error("%s mismatch: expected %0d, got %0d", name, want, got);
         fail_count++;
      end
   endtask

   // Receiver: cycles through always-ready, random stalls, periodic stalls and sparse ready.
   int unsigned rx_cycle = 0;
   always @(posedge clock) begin
      rx_cycle <= rx_cycle + 1;
      case (rx_cycle[9:8])
         2'd0:    rsp_tready <= 1'b1;
         2'd1:    rsp_tready <= ($urandom_range(0, 9) < 7);
         2'd2:    rsp_tready <= (rx_cycle[1:0] != 2'd3);
         default: rsp_tready <= ($urandom_range(0, 7) == 0);
      endcase
   end

   // Result checker: each accepted result against the oldest expectation.
   warn_result_type want_res;
   always @(posedge clock) begin
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (warn_queue.size() == 0) begin
            $error("Result item with no expectation waiting: tdata %h", rsp_tdata);
            fail_count++;
         end else begin
            want_res = warn_queue.pop_front();
            check_field("warn_status", want_res.warn_status, rsp_tdata[1:0]);
            check_field("status_set", want_res.status_set, rsp_tdata[2]);
            check_field("sampling_active", want_res.sampling_active, rsp_tdata[3]);
            check_field("went_idle", want_res.went_idle, rsp_tdata[4]);
            check_field("distance_cm", want_res.distance_cm, rsp_tdata[15:5]);
         end
      end
   end

   // Stimulus.
   initial begin
      int unsigned  live_items;
      int unsigned  phase_idx;
      int unsigned  phase_len;
      int unsigned  far_pct;
      int unsigned  cm;
      int unsigned  pick;
      logic         mode;
      logic [ECHO_W-1:0] echo_us;

      live_items = 0;
      phase_idx = 0;
      far_pct = 50;
      repeat (10) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Directed sequence.
      for (int i = 0; i < PLAN_ROWS; i++) begin
         if (DIRECTED_PLAN[i].kind == ROW_CSR) begin
            write_reg(DIRECTED_PLAN[i].reg_idx, DIRECTED_PLAN[i].reg_val);
         end else begin
            send_item(DIRECTED_PLAN[i].mode, DIRECTED_PLAN[i].echo_us,
                      DIRECTED_PLAN[i].typed, DIRECTED_PLAN[i].typed_res);
         end
      end

      // Random phases, each under its own register settings.
      while (live_items < RANDOM_ITEMS) begin
         case (phase_idx)
            0: begin
               write_reg(REG_DISTANCE_LIMIT, 11'd0);
               write_reg(REG_SETTLE_SAMPLES, 11'd0);
               write_reg(REG_IDLE_LIMIT, 11'd1);
            end
            1: begin
               write_reg(REG_DISTANCE_LIMIT, 11'd1200);
               write_reg(REG_SETTLE_SAMPLES, 11'd15);
               write_reg(REG_IDLE_LIMIT, 11'd255);
            end
            2: begin
               write_reg(REG_DISTANCE_LIMIT, 11'd1128);
               write_reg(REG_SETTLE_SAMPLES, 11'd15);
               write_reg(REG_IDLE_LIMIT, 11'd255);
            end
            default: begin
               write_reg(REG_DISTANCE_LIMIT, CSR_DATA_W'(($urandom_range(0, 9) == 0) ?
                         $urandom_range(0, 1200) : $urandom_range(0, 600)));
               write_reg(REG_SETTLE_SAMPLES, CSR_DATA_W'($urandom_range(0, 15)));
               write_reg(REG_IDLE_LIMIT, CSR_DATA_W'(($urandom_range(0, 3) == 0) ?
                         $urandom_range(1, 255) : $urandom_range(1, 12)));
            end
         endcase
         steady = ($urandom_range(0, 3) == 0);
         phase_len = (phase_idx < 3) ? 300 : $urandom_range(60, 180);

         for (int n = 0; n < phase_len; n++) begin
            echo_us = ECHO_W'($urandom_range(0, 65535));
            pick = $urandom_range(0, 99);
            if (!sampling) begin
               // Mostly start a new session; sometimes an echo that is ignored.
               mode = (pick < 85) ? MODE_MOTION : MODE_ECHO;
               if (mode == MODE_MOTION) far_pct = $urandom_range(30, 95);
            end else if (pick < 3) begin
               mode = MODE_MOTION;
            end else begin
               mode = MODE_ECHO;
               if (pick >= 8) begin
                  // Distances clustered around the limit, biased per session.
                  if ($urandom_range(0, 99) < far_pct && limit_cm < DIST_MAX) begin
                     cm = $urandom_range(limit_cm + 1,
                                         (limit_cm + 40 > DIST_MAX) ? DIST_MAX :
                                         limit_cm + 40);
                  end else if (limit_cm == 0 || $urandom_range(0, 9) == 0) begin
                     cm = (limit_cm > DIST_MAX) ? DIST_MAX : limit_cm;
                  end else begin
                     cm = $urandom_range((limit_cm > 40) ? limit_cm - 40 : 0,
                                         limit_cm - 1);
                  end
                  echo_us = echo_for(cm);
               end
            end
            if (mode == MODE_MOTION || sampling) live_items++;
            send_item(mode, echo_us, 1'b0, NO_RES);
         end
         phase_idx++;
      end

      // Let every result drain, then wait before finishing.
      req_tvalid <= 1'b0;
      while (warn_queue.size() != 0) @(posedge clock);
      repeat (10 * DRAIN_CYCLES) @(posedge clock);
      if (fail_count == 0) begin
         $display("DONE: 0 errors");
      end else begin
         $display("DONE: errors detected");
      end
      $finish;
   end

   // Run limit, far beyond the slowest correct run.
   initial begin
      #5_000_000;
      $display("DONE: errors detected");
      $finish;
   end

endmodule
